[rtl/srcd_pkg.sv]
// Shared types, command codes and constants of the sprite row command decoder.
package srcd_pkg;

   localparam int COORD_BITS_DEFAULT = 16;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 15;
   localparam logic [CSR_DATA_BITS-1:0] CLIP_LEFT_RESET  = 15'h0000;
   localparam logic [CSR_DATA_BITS-1:0] CLIP_RIGHT_RESET = 15'h7FFF;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_LEFT  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_RIGHT = 2'd1;

   // Low nibble of a command byte.
   localparam logic [3:0] OP_LONG_COPY = 4'h2;
   localparam logic [3:0] OP_LONG_SKIP = 4'h3;
   localparam logic [3:0] OP_RUN_COPY  = 4'h6;
   localparam logic [3:0] OP_FILL      = 4'h7;
   localparam logic [3:0] OP_ALT_FILL  = 4'hA;
   localparam logic [3:0] OP_SHADOW    = 4'hB;
   localparam logic [3:0] OP_EXTENDED  = 4'hE;
   localparam logic [3:0] OP_ROW_END   = 4'hF;

   // Whole bytes of the extended group.
   localparam logic [7:0] CMD_ADVANCE_ONE_A = 8'h4E;
   localparam logic [7:0] CMD_ADVANCE_ONE_B = 8'h6E;
   localparam logic [7:0] CMD_ADVANCE_N_A   = 8'h5E;
   localparam logic [7:0] CMD_ADVANCE_N_B   = 8'h7E;

   localparam logic FUNC_ROW_START = 1'b0;

   typedef enum logic [2:0] {
      KIND_COPY    = 3'd0,
      KIND_FILL    = 3'd1,
      KIND_ALT     = 3'd2,
      KIND_SHADOW  = 3'd3,
      KIND_ROW_END = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      MODE_IDLE       = 4'd0,
      MODE_CMD        = 4'd1,
      MODE_COPY       = 4'd2,
      MODE_LONG_LEN   = 4'd3,
      MODE_EXT_LEN    = 4'd4,
      MODE_SPAN_LEN   = 4'd5,
      MODE_FILL_COLOR = 4'd6,
      MODE_ALT_A      = 4'd7,
      MODE_ALT_B      = 4'd8
   } mode_type;

   typedef struct packed {
      logic               func;
      logic signed [15:0] row_x;
      logic signed [15:0] row_x_max;
      logic [7:0]         byte_value;
   } req_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] x_start;
      logic [7:0]         span_length;
      logic [7:0]         color_first;
      logic [7:0]         color_second;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

endpackage

[rtl/srcd_core.sv]
// Command decode, x tracking and span clipping for one stream word per cycle while step is high.
module srcd_core
   import srcd_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  req_type                  item,
   input  logic [CSR_DATA_BITS-1:0] clip_left,
   input  logic [CSR_DATA_BITS-1:0] clip_right,
   output result_type               result
);

   localparam int XW = COORD_BITS + 1;
   localparam int CW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
   localparam logic signed [CW-1:0] CMAX_W = CW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [CW-1:0] CMIN_W = ~CMAX_W;
   localparam logic signed [CW-1:0] XSAT_W = CMAX_W + CW'(1);

   mode_type                 mode_ff, mode_in;
   logic signed [XW-1:0]     current_x_ff, current_x_in;
   logic [11:0]              remaining_ff, remaining_in;
   logic [7:0]               pend_cmd_ff, pend_cmd_in;
   logic [7:0]               pend_len_ff, pend_len_in;
   logic [7:0]               held_ff, held_in;
   logic signed [COORD_BITS-1:0] limit_ff, limit_in;

   logic [7:0]  b;
   logic [3:0]  op;
   logic [3:0]  hi_n;
   logic [3:0]  start_op;
   logic [7:0]  start_n;
   logic [11:0] long_len;
   logic        span_op;
   mode_type    start_mode;

   // Actions decoded from the current word.
   logic        step_en;
   logic [11:0] step_val;
   logic        span_en;
   kind_type    span_kind;
   logic [7:0]  span_c1, span_c2;
   logic        row_end;
   logic        rem_load;
   logic [11:0] rem_val;
   logic        pend_cmd_load;
   logic        pend_len_load;
   logic        held_load;

   logic signed [CW-1:0] rx_w, rmx_w, rx_c, rmx_c;
   logic                 row_empty;
   logic signed [CW-1:0] x0_w, step_w, sum_w, x_sat_w;
   logic signed [CW-1:0] cl_w, cr_w, lim_w, lo_w, hi_w;
   logic                 visible, swap;
   logic [7:0]           count;

   assign b        = item.byte_value;
   assign op       = b[3:0];
   assign hi_n     = b[7:4];
   assign start_op = (mode_ff == MODE_CMD) ? op : pend_cmd_ff[3:0];
   assign start_n  = (mode_ff == MODE_CMD) ? {4'b0, hi_n} : b;
   assign long_len = {pend_cmd_ff[7:4], b};
   assign span_op  = (op == OP_RUN_COPY) || (op == OP_FILL) || (op == OP_ALT_FILL) ||
                     (op == OP_SHADOW);

   // Row start values are clamped to the coordinate range first.
   assign rx_w  = CW'(item.row_x);
   assign rmx_w = CW'(item.row_x_max);
   assign rx_c  = (rx_w < CMIN_W) ? CMIN_W : ((rx_w > CMAX_W) ? CMAX_W : rx_w);
   assign rmx_c = (rmx_w < CMIN_W) ? CMIN_W : ((rmx_w > CMAX_W) ? CMAX_W : rmx_w);
   assign row_empty = rmx_c < rx_c;

   always_comb begin
      case (start_op)
         OP_RUN_COPY: start_mode = (start_n != 8'd0) ? MODE_COPY : MODE_CMD;
         OP_FILL:     start_mode = MODE_FILL_COLOR;
         OP_ALT_FILL: start_mode = MODE_ALT_A;
         default:     start_mode = MODE_CMD;
      endcase
   end

   // Next decode mode.
   always_comb begin
      mode_in = mode_ff;
      if (step) begin
         if (item.func == FUNC_ROW_START) begin
            mode_in = row_empty ? MODE_IDLE : MODE_CMD;
         end else begin
            case (mode_ff)
               MODE_CMD: begin
                  if (op == OP_ROW_END) begin
                     mode_in = MODE_IDLE;
                  end else if ((op == OP_LONG_COPY) || (op == OP_LONG_SKIP)) begin
                     mode_in = MODE_LONG_LEN;
                  end else if (span_op) begin
                     mode_in = (hi_n == 4'd0) ? MODE_SPAN_LEN : start_mode;
                  end else if (op == OP_EXTENDED) begin
                     if ((b == CMD_ADVANCE_N_A) || (b == CMD_ADVANCE_N_B)) begin
                        mode_in = MODE_EXT_LEN;
                     end
                  end else if (!op[0] && (b[7:2] != 6'd0)) begin
                     mode_in = MODE_COPY;
                  end
               end
               MODE_COPY: begin
                  if (remaining_ff <= 12'd1) begin
                     mode_in = MODE_CMD;
                  end
               end
               MODE_LONG_LEN: begin
                  mode_in = ((pend_cmd_ff[3:0] != OP_LONG_SKIP) && (long_len != 12'd0)) ?
                            MODE_COPY : MODE_CMD;
               end
               MODE_SPAN_LEN:   mode_in = start_mode;
               MODE_ALT_A:      mode_in = MODE_ALT_B;
               MODE_EXT_LEN,
               MODE_FILL_COLOR,
               MODE_ALT_B:      mode_in = MODE_CMD;
               default:         mode_in = mode_ff;
            endcase
         end
      end
   end

   // Word actions. A span moves x by its full length, saturating just past the coordinate range.
   always_comb begin
      step_en       = 1'b0;
      step_val      = 12'd0;
      span_en       = 1'b0;
      span_kind     = KIND_COPY;
      span_c1       = 8'd0;
      span_c2       = 8'd0;
      row_end       = 1'b0;
      rem_load      = 1'b0;
      rem_val       = 12'd0;
      pend_cmd_load = 1'b0;
      pend_len_load = 1'b0;
      held_load     = 1'b0;
      if (step && (item.func != FUNC_ROW_START)) begin
         case (mode_ff)
            MODE_CMD: begin
               if (op == OP_ROW_END) begin
                  row_end = 1'b1;
               end else if ((op == OP_LONG_COPY) || (op == OP_LONG_SKIP)) begin
                  pend_cmd_load = 1'b1;
               end else if (span_op) begin
                  pend_cmd_load = 1'b1;
                  if (hi_n != 4'd0) begin
                     pend_len_load = 1'b1;
                     if (op == OP_RUN_COPY) begin
                        rem_load = 1'b1;
                        rem_val  = {4'b0, start_n};
                     end else if (op == OP_SHADOW) begin
                        span_en   = 1'b1;
                        span_kind = KIND_SHADOW;
                        step_en   = 1'b1;
                        step_val  = {4'b0, start_n};
                     end
                  end
               end else if (op == OP_EXTENDED) begin
                  if ((b == CMD_ADVANCE_ONE_A) || (b == CMD_ADVANCE_ONE_B)) begin
                     step_en  = 1'b1;
                     step_val = 12'd1;
                  end else if ((b == CMD_ADVANCE_N_A) || (b == CMD_ADVANCE_N_B)) begin
                     pend_cmd_load = 1'b1;
                  end
               end else if (op[0]) begin
                  step_en  = 1'b1;
                  step_val = {6'b0, b[7:2]};
               end else if (b[7:2] != 6'd0) begin
                  rem_load = 1'b1;
                  rem_val  = {6'b0, b[7:2]};
               end
            end
            MODE_COPY: begin
               rem_load = 1'b1;
               rem_val  = (remaining_ff <= 12'd1) ? 12'd0 : (remaining_ff - 12'd1);
               span_en  = 1'b1;
               span_kind = KIND_COPY;
               span_c1  = b;
               step_en  = 1'b1;
               step_val = 12'd1;
            end
            MODE_LONG_LEN: begin
               if (pend_cmd_ff[3:0] == OP_LONG_SKIP) begin
                  step_en  = 1'b1;
                  step_val = long_len;
               end else if (long_len != 12'd0) begin
                  rem_load = 1'b1;
                  rem_val  = long_len;
               end
            end
            MODE_EXT_LEN: begin
               step_en  = 1'b1;
               step_val = {4'b0, b};
            end
            MODE_SPAN_LEN: begin
               pend_len_load = 1'b1;
               if (start_op == OP_RUN_COPY) begin
                  rem_load = 1'b1;
                  rem_val  = {4'b0, start_n};
               end else if ((start_op != OP_FILL) && (start_op != OP_ALT_FILL)) begin
                  span_en   = 1'b1;
                  span_kind = KIND_SHADOW;
                  step_en   = 1'b1;
                  step_val  = {4'b0, start_n};
               end
            end
            MODE_FILL_COLOR: begin
               span_en   = 1'b1;
               span_kind = KIND_FILL;
               span_c1   = b;
               step_en   = 1'b1;
               step_val  = {4'b0, pend_len_ff};
            end
            MODE_ALT_A: begin
               held_load = 1'b1;
            end
            MODE_ALT_B: begin
               span_en   = 1'b1;
               span_kind = KIND_ALT;
               span_c1   = held_ff;
               span_c2   = b;
               step_en   = 1'b1;
               step_val  = {4'b0, pend_len_ff};
            end
            default: begin
               step_en = 1'b0;
            end
         endcase
      end
   end

   // Clip and advance: one add for the new x, then compares against the clip window and the row's last visible x.
   assign x0_w    = CW'(current_x_ff);
   assign step_w  = CW'($signed({1'b0, step_val}));
   assign sum_w   = x0_w + step_w;
   assign x_sat_w = (sum_w > XSAT_W) ? XSAT_W : sum_w;
   assign cl_w    = CW'($signed({1'b0, clip_left}));
   assign cr_w    = CW'($signed({1'b0, clip_right}));
   assign lim_w   = CW'(limit_ff);

   always_comb begin
      lo_w = (x0_w > cl_w) ? x0_w : cl_w;
      hi_w = sum_w - CW'(1);
      if (hi_w > cr_w) begin
         hi_w = cr_w;
      end
      if (hi_w > lim_w) begin
         hi_w = lim_w;
      end
   end

   // An empty span also lands here, since its last pixel lies before its first.
   assign visible = hi_w >= lo_w;
   assign count   = 8'(hi_w - lo_w + CW'(1));
   assign swap    = (span_kind == KIND_ALT) && (lo_w[0] ^ x0_w[0]);

   always_comb begin
      result.valid             = row_end || (span_en && visible);
      result.data.kind         = row_end ? KIND_ROW_END : span_kind;
      result.data.x_start      = row_end ? 16'sd0 : 16'(lo_w);
      result.data.span_length  = row_end ? 8'd0 : count;
      result.data.color_first  = swap ? span_c2 : span_c1;
      result.data.color_second = swap ? span_c1 : span_c2;
   end

   always_comb begin
      current_x_in = current_x_ff;
      remaining_in = remaining_ff;
      pend_cmd_in  = pend_cmd_ff;
      pend_len_in  = pend_len_ff;
      held_in      = held_ff;
      limit_in     = limit_ff;
      if (step && (item.func == FUNC_ROW_START)) begin
         current_x_in = XW'(rx_c);
         limit_in     = COORD_BITS'(rmx_c);
         remaining_in = 12'd0;
         pend_cmd_in  = 8'd0;
         pend_len_in  = 8'd0;
         held_in      = 8'd0;
      end else begin
         if (step_en) begin
            current_x_in = XW'(x_sat_w);
         end
         if (rem_load) begin
            remaining_in = rem_val;
         end
         if (pend_cmd_load) begin
            pend_cmd_in = b;
         end
         if (pend_len_load) begin
            pend_len_in = start_n;
         end
         if (held_load) begin
            held_in = b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         current_x_ff <= '0;
         remaining_ff <= 12'd0;
         pend_cmd_ff  <= 8'd0;
         pend_len_ff  <= 8'd0;
         held_ff      <= 8'd0;
         limit_ff     <= '0;
      end else begin
         mode_ff      <= mode_in;
         current_x_ff <= current_x_in;
         remaining_ff <= remaining_in;
         pend_cmd_ff  <= pend_cmd_in;
         pend_len_ff  <= pend_len_in;
         held_ff      <= held_in;
         limit_ff     <= limit_in;
      end
   end

endmodule

[rtl/srcd_out_buf.sv]
// Two-entry result buffer that registers the result channel.
module srcd_out_buf
   import srcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  result_type result,
   output logic       full,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push      = result.valid;
   assign pop       = (count_ff != 2'd0) && rsp_ready;
   assign full      = count_ff == 2'd2;
   assign rsp_valid = count_ff != 2'd0;
   assign rsp_data  = slot0_ff;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
      if (push && ((count_ff == 2'd0) || ((count_ff == 2'd1) && pop))) begin
         slot0_in = result.data;
      end else if (pop && (count_ff == 2'd2)) begin
         slot0_in = slot1_ff;
      end
      if (push && (count_ff == 2'd1) && !pop) begin
         slot1_in = result.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

[rtl/sprite_row_command_decoder.sv]
// Top level of the sprite row command decoder: input register, clip registers and result buffer.
//
// Usage: a row-start word (func 0) loads the row's start x and last visible x; each
// following word (func 1) carries one byte of the row's command stream. Results leave
// on the rsp_ channel as clipped copy pixels, fill, alternating or shadow spans, and
// a row-end marker; a word causes at most one result.
// Both channels use valid/ready. A word is registered on acceptance and decoded while
// it sits in the input register and the buffer has room; its result enters the buffer
// at the end of that decode, and rsp_valid rises as the buffer becomes non-empty.
// Throughput is one word per cycle while the buffer has room: the command state and current x
// are updated by one short decode, one add and a few compares, all combinational.
// The result side is a two-entry buffer; while the receiver stalls, the block keeps
// taking words until the buffer and the input register are full, and ready depends
// only on registers.
// The clip registers are written through csr_ with no wait; write them only while
// the block is idle. Synchronous reset empties both channels, restores the clip
// window to its full range and leaves the decoder waiting for a row start.
module sprite_row_command_decoder
   import srcd_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic                     s1_valid_ff, s1_valid_in;
   req_type                  s1_item_ff, s1_item_in;
   logic [CSR_DATA_BITS-1:0] clip_left_ff, clip_left_in;
   logic [CSR_DATA_BITS-1:0] clip_right_ff, clip_right_in;
   logic                     out_full;
   logic                     proc;
   logic                     req_accept;
   result_type               result;

   assign proc       = s1_valid_ff && !out_full;
   assign req_ready  = !s1_valid_ff || !out_full;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      s1_valid_in = req_accept || (s1_valid_ff && !proc);
      s1_item_in  = req_accept ? req_data : s1_item_ff;
   end

   always_comb begin
      clip_left_in  = clip_left_ff;
      clip_right_in = clip_right_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CLIP_LEFT:  clip_left_in  = csr_wdata;
            CSR_CLIP_RIGHT: clip_right_in = csr_wdata;
            default:        clip_left_in  = clip_left_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         clip_left_ff  <= CLIP_LEFT_RESET;
         clip_right_ff <= CLIP_RIGHT_RESET;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         clip_left_ff  <= clip_left_in;
         clip_right_ff <= clip_right_in;
      end
      s1_item_ff <= s1_item_in;
   end

   srcd_core #(
      .COORD_BITS (COORD_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (proc),
      .item       (s1_item_ff),
      .clip_left  (clip_left_ff),
      .clip_right (clip_right_ff),
      .result     (result)
   );

   srcd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .full      (out_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // A result is only ever produced by a word that is being decoded.
   a_result_needs_word: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> proc)
      else $error("result produced without a word being decoded");

   // The buffer must never be offered a result when it is full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> !out_full)
      else $error("result pushed into a full buffer");

   // Clipping never lets an empty pixel or span through.
   a_span_not_empty: assert property (@(posedge clock) disable iff (reset)
      (result.valid && (result.data.kind != KIND_ROW_END)) |->
         (result.data.span_length != 8'd0))
      else $error("empty span produced");

   // A word held in the input register is decoded once the buffer has room.
   a_word_drains: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_full) |=> ($past(req_accept) || !s1_valid_ff))
      else $error("input word not consumed");
`endif

endmodule
